// ===== rtl/core/dte_pkg.sv =====
package dte_pkg;

    // text codes
    localparam logic [7:0] NEWLINE_CODE = 8'h0a;

    // pattern registers hold up to eight characters
    localparam int PAT_BYTES = 8;
    localparam int PAT_W     = 8 * PAT_BYTES;

    // configuration register indexes
    localparam logic [1:0] REG_PREFIX_BYTES  = 2'd0;
    localparam logic [1:0] REG_PREFIX_LENGTH = 2'd1;
    localparam logic [1:0] REG_SUFFIX_BYTES  = 2'd2;
    localparam logic [1:0] REG_SUFFIX_LENGTH = 2'd3;

    // per-cycle commands shared by every cell of a chain
    typedef struct packed {
        logic shift;     // take the right neighbour's byte
        logic load;      // the incoming character lands at the load position
        logic cmp_next;  // compare on the updated byte rather than the pre-shift view
    } t_cell_ctl;

    // one result item
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       record_end;
    } t_result;

endpackage

// ===== rtl/core/dte_cell.sv =====
module dte_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic                     i_clk,
    input  dte_pkg::t_cell_ctl       i_ctl,
    input  logic [IW-1:0]            i_load_pos,
    input  logic [7:0]               i_char,
    input  logic [7:0]               i_right,
    input  logic [IW-1:0]            i_base,
    input  logic [IW-1:0]            i_span,
    input  logic [dte_pkg::PAT_W-1:0] i_pattern,
    output logic [7:0]               o_byte,
    output logic                     o_ok
);

    localparam logic [IW-1:0] POS      = IW'(IDX);
    localparam logic [IW-1:0] POS_NEXT = IW'(IDX + 1);

    logic [7:0]    r_byte;
    logic [7:0]    w_byte;
    logic [7:0]    n_byte;
    logic [7:0]    cmp_byte;
    logic          in_win;
    logic [IW-1:0] diff;
    logic [IW+2:0] diff_ext;
    logic [2:0]    pidx;

    // view with the new character appended, before any shift
    assign w_byte = (i_ctl.load && (i_load_pos == POS)) ? i_char : r_byte;

    always_comb begin
        if (i_ctl.shift) begin
            n_byte = (i_ctl.load && (i_load_pos == POS_NEXT)) ? i_char : i_right;
        end else begin
            n_byte = w_byte;
        end
    end

    assign cmp_byte = i_ctl.cmp_next ? n_byte : w_byte;

    // position inside the compare window, counted from its first byte
    assign in_win   = (POS >= i_base) && (POS < i_span);
    assign diff     = POS - i_base;
    assign diff_ext = {3'b000, diff};
    assign pidx     = diff_ext[2:0];

    assign o_ok   = !in_win || (cmp_byte == i_pattern[pidx*8 +: 8]);
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// ===== rtl/core/dte_out_skid.sv =====
module dte_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dte_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_take,
    output dte_pkg::t_result o_res
);

    logic             r_valid;
    logic             r_skid_valid;
    dte_pkg::t_result r_main;
    dte_pkg::t_result r_skid;
    logic             advance;

    assign advance = !r_valid || i_take;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (advance) begin
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

// ===== rtl/core/delimited_text_extractor.sv =====
// delimited text extractor
// input channel (s): one text byte per item, tdata = char_code, tlast = end_of_input.
// a line closes at a newline byte (not part of the line) or after an item with tlast.
// in each line the first occurrence of the prefix opens a record; the bytes after it
// are sent out up to the first suffix that starts after the prefix, or to line end.
// output channel (m): tdata = extracted byte, tuser = has_char, tlast = record_end.
// an item with tuser low is a marker: it closes a record whose bytes already left,
// or stands alone for an empty record.
// patterns are written through the cfg port; the user must write them only while no
// item is in flight, which the block itself does not enforce. a result is registered
// in the output stage before it shows on the m side; a byte is held until it cannot
// start the suffix, so text lags by up to suffix length minus one items.
// throughput: one item per cycle while o_s_tready is high; an item releasing several
// results holds it low as the hold cells drain one byte a cycle while out_ready is high.
// the hold window and prefix window are rows of byte cells that shift towards
// index 0; each cell checks its own byte against the pattern in the same cycle.
// a two-entry output stage lets input continue while a result waits; when the
// receiver stalls that stage fills and o_s_tready drops.
// reset clears line state, counts, the output stage and the pattern registers
// (lengths back to one, bytes to zero); cell bytes are not cleared.
module delimited_text_extractor #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    // text in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,   // end_of_input
    // results out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_char
    output logic [0:0]  o_m_tuser,   // [0] has_char
    output logic        o_m_tlast    // record_end
);

    // cells per window; patterns never exceed eight characters
    localparam int CAP = (MAX_DELIM_BYTES < dte_pkg::PAT_BYTES) ? MAX_DELIM_BYTES
                                                               : dte_pkg::PAT_BYTES;
    localparam int IW  = $clog2(CAP + 1);
    localparam logic [IW-1:0] CAP_W  = IW'(CAP);
    localparam logic [IW-1:0] ONE_W  = IW'(1);
    localparam logic [3:0]    CAP4   = 4'(CAP);

    // line modes
    localparam logic [1:0] MODE_SEEK = 2'd0;  // looking for the prefix
    localparam logic [1:0] MODE_COPY = 2'd1;  // inside a record
    localparam logic [1:0] MODE_SKIP = 2'd2;  // record done, rest of line dropped

    // pattern registers
    logic [63:0]   r_pfx_bytes;
    logic [3:0]    r_pfx_len;
    logic [63:0]   r_sfx_bytes;
    logic [3:0]    r_sfx_len;

    // line and drain state
    logic [1:0]    r_mode,    n_mode;
    logic [IW-1:0] r_fill,    n_fill;    // bytes in the prefix window
    logic [IW-1:0] r_cnt,     n_cnt;     // bytes in the hold window, pending ones included
    logic [IW-1:0] r_drain,   n_drain;   // front bytes still to be sent
    logic          r_mark,    n_mark;    // marker follows the drained bytes
    logic          r_endlast, n_endlast; // last drained byte ends the record

    // effective lengths
    logic [3:0]    plen4, slen4;
    logic [IW-1:0] plen, slen;

    // handshake and decode
    logic          out_ready;
    logic          accept;
    logic          nl, eoi;
    logic          seek, copy;
    logic          draining;

    // prefix window
    dte_pkg::t_cell_ctl pfx_ctl;
    logic [IW-1:0] fill_new;
    logic [IW-1:0] pfx_base;
    logic [7:0]    pfx_byte  [CAP];
    logic [7:0]    pfx_right [CAP];
    logic [CAP-1:0] pfx_ok;
    logic          pfx_hit;

    // hold window
    dte_pkg::t_cell_ctl hold_ctl;
    logic          hold_shift;
    logic [IW-1:0] m;
    logic [IW-1:0] sfx_base;
    logic [7:0]    hold_byte  [CAP];
    logic [7:0]    hold_right [CAP];
    logic [CAP-1:0] hold_ok;
    logic          sfx_hit;
    logic [7:0]    w0;

    // result push into the output stage
    logic             push;
    dte_pkg::t_result res;
    dte_pkg::t_result out_res;

    // 0 acts as 1, anything above the cell count acts as the cell count
    assign plen4 = (r_pfx_len == 4'd0) ? 4'd1 : ((r_pfx_len > CAP4) ? CAP4 : r_pfx_len);
    assign slen4 = (r_sfx_len == 4'd0) ? 4'd1 : ((r_sfx_len > CAP4) ? CAP4 : r_sfx_len);
    assign plen  = plen4[IW-1:0];
    assign slen  = slen4[IW-1:0];

    assign draining   = (r_drain != '0) || r_mark;
    assign o_s_tready = out_ready && !draining;
    assign accept     = i_s_tvalid && o_s_tready;
    assign nl         = (i_s_tdata == dte_pkg::NEWLINE_CODE);
    assign eoi        = i_s_tlast;
    assign seek       = (r_mode == MODE_SEEK);
    assign copy       = (r_mode == MODE_COPY);

    // prefix window: appends while filling, shifts once full
    assign fill_new = (r_fill == CAP_W) ? CAP_W : r_fill + ONE_W;
    assign pfx_base = fill_new - plen;
    assign pfx_hit  = (fill_new >= plen) && (&pfx_ok);

    always_comb begin
        pfx_ctl.load     = accept && seek && !nl;
        pfx_ctl.shift    = accept && seek && !nl && (r_fill == CAP_W);
        pfx_ctl.cmp_next = 1'b1;
    end

    // hold window: held bytes plus the new one, suffix checked at its tail
    assign m        = r_cnt + ONE_W;
    assign sfx_base = m - slen;
    assign sfx_hit  = (m >= slen) && (&hold_ok);
    assign w0       = (r_cnt == '0) ? i_s_tdata : hold_byte[0];

    always_comb begin
        hold_ctl.load     = accept && copy && !nl;
        hold_ctl.shift    = hold_shift;
        hold_ctl.cmp_next = 1'b0;
    end

    generate
        for (genvar g = 0; g < CAP; g++) begin : g_cells
            if (g == CAP - 1) begin : g_end
                assign pfx_right[g]  = 8'h00;
                assign hold_right[g] = 8'h00;
            end else begin : g_mid
                assign pfx_right[g]  = pfx_byte[g+1];
                assign hold_right[g] = hold_byte[g+1];
            end

            dte_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_pfx_cell (
                .i_clk      (i_clk),
                .i_ctl      (pfx_ctl),
                .i_load_pos (r_fill),
                .i_char     (i_s_tdata),
                .i_right    (pfx_right[g]),
                .i_base     (pfx_base),
                .i_span     (fill_new),
                .i_pattern  (r_pfx_bytes),
                .o_byte     (pfx_byte[g]),
                .o_ok       (pfx_ok[g])
            );

            dte_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_hold_cell (
                .i_clk      (i_clk),
                .i_ctl      (hold_ctl),
                .i_load_pos (r_cnt),
                .i_char     (i_s_tdata),
                .i_right    (hold_right[g]),
                .i_base     (sfx_base),
                .i_span     (m),
                .i_pattern  (r_sfx_bytes),
                .o_byte     (hold_byte[g]),
                .o_ok       (hold_ok[g])
            );
        end
    endgenerate

    // line control; the first result of an item goes out in its own cycle,
    // any further ones drain from the front of the hold window
    always_comb begin
        n_mode     = r_mode;
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        n_drain    = r_drain;
        n_mark     = r_mark;
        n_endlast  = r_endlast;
        hold_shift = 1'b0;
        push       = 1'b0;
        res        = '0;

        if (draining) begin
            if (out_ready) begin
                push = 1'b1;
                if (r_drain != '0) begin
                    res.out_char   = hold_byte[0];
                    res.has_char   = 1'b1;
                    res.record_end = r_endlast && (r_drain == ONE_W);
                    hold_shift     = 1'b1;
                    n_cnt          = r_cnt - ONE_W;
                    n_drain        = r_drain - ONE_W;
                end else begin
                    res.record_end = 1'b1;
                    n_mark         = 1'b0;
                end
            end
        end else if (accept) begin
            if (seek) begin
                if (!nl) begin
                    n_fill = fill_new;
                    if (pfx_hit) begin
                        n_mode = MODE_COPY;
                        n_cnt  = '0;
                    end
                end
                if (nl || eoi) begin
                    // prefix right at line end: empty record
                    if (!nl && pfx_hit) begin
                        push           = 1'b1;
                        res.record_end = 1'b1;
                    end
                    n_mode = MODE_SEEK;
                    n_fill = '0;
                    n_cnt  = '0;
                end
            end else if (copy) begin
                if (nl) begin
                    // flush the held bytes, last one closes the record
                    push   = 1'b1;
                    n_mode = MODE_SEEK;
                    n_fill = '0;
                    if (r_cnt == '0) begin
                        res.record_end = 1'b1;
                        n_cnt          = '0;
                    end else begin
                        res.out_char   = hold_byte[0];
                        res.has_char   = 1'b1;
                        res.record_end = (r_cnt == ONE_W);
                        hold_shift     = 1'b1;
                        n_cnt          = r_cnt - ONE_W;
                        n_drain        = r_cnt - ONE_W;
                        n_endlast      = 1'b1;
                    end
                end else if (sfx_hit) begin
                    // bytes ahead of the suffix go out, then the closing marker
                    push   = 1'b1;
                    n_mode = eoi ? MODE_SEEK : MODE_SKIP;
                    if (eoi) begin
                        n_fill = '0;
                    end
                    if (sfx_base == '0) begin
                        res.record_end = 1'b1;
                        n_cnt          = '0;
                    end else begin
                        res.out_char = w0;
                        res.has_char = 1'b1;
                        hold_shift   = 1'b1;
                        n_cnt        = sfx_base - ONE_W;
                        n_drain      = sfx_base - ONE_W;
                        n_mark       = 1'b1;
                        n_endlast    = 1'b0;
                    end
                end else if (eoi) begin
                    // text ends inside the record: everything goes
                    push           = 1'b1;
                    res.out_char   = w0;
                    res.has_char   = 1'b1;
                    res.record_end = (m == ONE_W);
                    hold_shift     = 1'b1;
                    n_cnt          = m - ONE_W;
                    n_drain        = m - ONE_W;
                    n_endlast      = 1'b1;
                    n_mode         = MODE_SEEK;
                    n_fill         = '0;
                end else if (m >= slen) begin
                    // release what can no longer start the suffix
                    push         = 1'b1;
                    res.out_char = w0;
                    res.has_char = 1'b1;
                    hold_shift   = 1'b1;
                    n_cnt        = m - ONE_W;
                    n_drain      = sfx_base;
                    n_endlast    = 1'b0;
                end else begin
                    n_cnt = m;
                end
            end else begin
                // rest of line dropped; unused mode code behaves the same
                if (nl || eoi) begin
                    n_mode = MODE_SEEK;
                    n_fill = '0;
                    n_cnt  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SEEK;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_drain   <= '0;
            r_mark    <= 1'b0;
            r_endlast <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_drain   <= n_drain;
            r_mark    <= n_mark;
            r_endlast <= n_endlast;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx_bytes <= '0;
            r_pfx_len   <= 4'd1;
            r_sfx_bytes <= '0;
            r_sfx_len   <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dte_pkg::REG_PREFIX_BYTES:  r_pfx_bytes <= i_cfg_wdata;
                dte_pkg::REG_PREFIX_LENGTH: r_pfx_len   <= i_cfg_wdata[3:0];
                dte_pkg::REG_SUFFIX_BYTES:  r_sfx_bytes <= i_cfg_wdata;
                dte_pkg::REG_SUFFIX_LENGTH: r_sfx_len   <= i_cfg_wdata[3:0];
            endcase
        end
    end

    // output stage with skid entry
    dte_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_m_tvalid),
        .i_take  (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata    = out_res.out_char;
    assign o_m_tuser[0] = out_res.has_char;
    assign o_m_tlast    = out_res.record_end;

endmodule

// ===== rtl/core/dte_checker.sv =====
module dte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       i_s_tready,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic [0:0] i_m_tuser,
    input logic       i_m_tlast
);

    // a marker carries no byte and always closes a record
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser[0]) |-> (i_m_tlast && (i_m_tdata == 8'h00)))
        else $error("marker item with data or without record end");

    // nothing is offered straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result offered after reset");

    // a new result follows an accepted text item or a drain cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> ($past(i_s_tvalid && i_s_tready) || $past(!i_s_tready)))
        else $error("result appeared with no item behind it");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast)))
        else $error("stalled result changed");

endmodule

bind delimited_text_extractor dte_checker u_dte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

// ===== bench/tb_delimited_text_extractor.sv =====
`timescale 1ns / 1ps

module tb_delimited_text_extractor;

    localparam int MAX_DELIM   = 8;
    localparam int DELIM_CAP   = (MAX_DELIM < dte_pkg::PAT_BYTES) ? MAX_DELIM
                                                                  : dte_pkg::PAT_BYTES;
    // longest quiet stretch a correct run can show is the long receiver hold-off
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 27;
    localparam int NUM_PHASES  = 9;

    // where a line stands in the scan
    typedef enum logic [1:0] {
        SEEK_PREFIX,
        IN_RECORD,
        SKIP_LINE,
        SPARE_MODE
    } t_line_state;

    // one text item as offered on the input side
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_text_item;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_addr  = dte_pkg::REG_PREFIX_BYTES;
    logic [63:0] i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tlast;

    delimited_text_extractor #(
        .MAX_DELIM_BYTES(MAX_DELIM)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // text waiting to be offered, and the results the extractor owes us
    t_text_item       text_q[$];
    dte_pkg::t_result due_results[$];

    // pattern registers as the extractor should hold them
    logic [63:0] pref_pat;
    logic [3:0]  pref_len;
    logic [63:0] suf_pat;
    logic [3:0]  suf_len;

    // line state of the predictor
    t_line_state mode;
    logic [7:0]  pwin[DELIM_CAP];
    int          pfill;
    logic [7:0]  hwin[DELIM_CAP];
    int          hcount;

    int  err_count    = 0;
    int  pushed_cnt   = 0;
    int  accepted_cnt = 0;
    int  result_cnt   = 0;
    int  record_cnt   = 0;
    int  setting_cnt  = 0;
    int  idle_cycles  = 0;

    // handshake flags passed from the sampling edge to the driving edge
    bit  s_taken = 1'b0;
    bit  m_taken = 1'b0;

    // sender and receiver pacing
    int  s_gap = 0;
    int  s_run = 0;
    bit  sender_eager = 1'b0;
    int  r_wait = 0;
    int  r_run = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // lengths of 0 act as 1, anything past the window acts as the window
    function automatic int clamp_len(input logic [3:0] v);
        if (v == 4'd0)
            return 1;
        if (int'(v) > DELIM_CAP)
            return DELIM_CAP;
        return int'(v);
    endfunction

    function automatic void push_result(input logic [7:0] ch, input logic has,
                                        input logic closes);
        dte_pkg::t_result r;
        r.out_char   = ch;
        r.has_char   = has;
        r.record_end = closes;
        due_results = {due_results, r};
    endfunction

    function automatic void close_line();
        mode   = SEEK_PREFIX;
        pfill  = 0;
        hcount = 0;
    endfunction

    function automatic void reset_extractor_model();
        pref_pat = '0;
        pref_len = 4'd1;
        suf_pat  = '0;
        suf_len  = 4'd1;
        for (int i = 0; i < DELIM_CAP; i++) begin
            pwin[i] = '0;
            hwin[i] = '0;
        end
        close_line();
    endfunction

    // works out what one accepted text item releases and queues it
    function automatic void extract_predict(input logic [7:0] ch, input logic eoi);
        logic [7:0] w[8];
        int         m;
        int         plen;
        int         slen;
        int         rel;
        logic       nl;
        logic       same;

        nl = (ch == dte_pkg::NEWLINE_CODE);
        case (mode)
            SEEK_PREFIX: begin
                if (!nl) begin
                    plen = clamp_len(pref_len);
                    // prefix window slides once full
                    if (pfill >= DELIM_CAP) begin
                        for (int i = 1; i < DELIM_CAP; i++)
                            pwin[i-1] = pwin[i];
                        pwin[DELIM_CAP-1] = ch;
                    end else begin
                        pwin[pfill] = ch;
                        pfill++;
                    end
                    if (pfill >= plen) begin
                        same = 1'b1;
                        for (int i = 0; i < plen; i++)
                            if (pwin[pfill-plen+i] != pref_pat[8*i +: 8])
                                same = 1'b0;
                        if (same) begin
                            mode   = IN_RECORD;
                            hcount = 0;
                        end
                    end
                end
                if (nl || eoi) begin
                    // prefix closing the line gives an empty record
                    if (mode == IN_RECORD)
                        push_result(8'h00, 1'b0, 1'b1);
                    close_line();
                end
            end
            IN_RECORD: begin
                slen = clamp_len(suf_len);
                if (nl) begin
                    if (hcount == 0)
                        push_result(8'h00, 1'b0, 1'b1);
                    else
                        for (int i = 0; i < hcount; i++)
                            push_result(hwin[i], 1'b1, i == hcount - 1);
                    close_line();
                end else begin
                    m = 0;
                    for (int i = 0; i < hcount && i < 7; i++) begin
                        w[m] = hwin[i];
                        m++;
                    end
                    w[m] = ch;
                    m++;
                    same = 1'b0;
                    if (m >= slen) begin
                        same = 1'b1;
                        for (int i = 0; i < slen; i++)
                            if (w[m-slen+i] != suf_pat[8*i +: 8])
                                same = 1'b0;
                    end
                    if (same) begin
                        // bytes before the suffix leave open, a marker closes
                        for (int i = 0; i + slen < m; i++)
                            push_result(w[i], 1'b1, 1'b0);
                        push_result(8'h00, 1'b0, 1'b1);
                        mode   = SKIP_LINE;
                        hcount = 0;
                        if (eoi)
                            close_line();
                    end else if (eoi) begin
                        for (int i = 0; i < m; i++)
                            push_result(w[i], 1'b1, i == m - 1);
                        close_line();
                    end else if (m >= slen) begin
                        // release whatever can no longer start the suffix,
                        // including surplus left by a shorter suffix length
                        rel = m - slen + 1;
                        for (int i = 0; i < rel; i++)
                            push_result(w[i], 1'b1, 1'b0);
                        hcount = 0;
                        for (int i = rel; i < m; i++) begin
                            hwin[hcount] = w[i];
                            hcount++;
                        end
                    end else begin
                        for (int i = 0; i < m; i++)
                            hwin[i] = w[i];
                        hcount = m;
                    end
                end
            end
            default: begin
                if (nl || eoi)
                    close_line();
            end
        endcase
    endfunction

    // wait per item: long runs with none, otherwise a random draw
    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // ---------------------------------------------------------------
    // input driver: offers queued text items, changes at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : text_driver
        t_text_item it;
        logic       offer;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            offer = i_s_tvalid && !s_taken;
            s_taken = 1'b0;
            if (!offer) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (text_q.size() != 0) begin
                    it = text_q.pop_front();
                    i_s_tdata <= it.ch;
                    i_s_tlast <= it.eoi;
                    offer = 1'b1;
                    s_gap = sender_eager ? 0 : draw_wait(s_run);
                end
            end
            // one assignment per step keeps back-to-back items clean
            i_s_tvalid <= offer;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall per result, plus one long hold-off on request
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : result_sink
        if (m_taken) begin
            m_taken = 1'b0;
            r_wait  = draw_wait(r_run);
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (r_wait > 0) begin
            r_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // monitor: samples both handshakes at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        dte_pkg::t_result got;
        dte_pkg::t_result want;
        if (i_rst_n) begin
            // results first, so an item taken on this edge cannot feed this check
            if (o_m_tvalid && i_m_tready) begin
                m_taken = 1'b1;
                got.out_char   = o_m_tdata;
                got.has_char   = o_m_tuser[0];
                got.record_end = o_m_tlast;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d (char %02h has %0b end %0b) unexpected",
                                              result_cnt, got.out_char, got.has_char,
                                              got.record_end));
                end else begin
                    want = due_results.pop_front();
                    if (got.out_char !== want.out_char)
                        report_mismatch($sformatf("result %0d out_char %02h, expected %02h",
                                                  result_cnt, got.out_char, want.out_char));
                    if (got.has_char !== want.has_char)
                        report_mismatch($sformatf("result %0d has_char %0b, expected %0b",
                                                  result_cnt, got.has_char, want.has_char));
                    if (got.record_end !== want.record_end)
                        report_mismatch($sformatf("result %0d record_end %0b, expected %0b",
                                                  result_cnt, got.record_end, want.record_end));
                end
                if (got.record_end === 1'b1)
                    record_cnt++;
                result_cnt++;
            end
            if (i_s_tvalid && o_s_tready) begin
                s_taken = 1'b1;
                extract_predict(i_s_tdata, i_s_tlast);
                accepted_cnt++;
            end
        end
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || i_cfg_we || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results still due",
                     STALL_LIMIT, due_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic void push_item(input logic [7:0] ch, input logic eoi);
        t_text_item it;
        it.ch  = ch;
        it.eoi = eoi;
        text_q = {text_q, it};
        pushed_cnt++;
    endfunction

    function automatic void push_pattern(input logic [63:0] pat, input int len);
        for (int i = 0; i < len; i++)
            push_item(pat[8*i +: 8], 1'b0);
    endfunction

    // mostly pattern characters, so partial and overlapping matches turn up
    function automatic logic [7:0] text_byte();
        int k;
        int idx;
        k = $urandom_range(0, 9);
        if (k < 4) begin
            idx = $urandom_range(0, clamp_len(pref_len) - 1);
            return pref_pat[8*idx +: 8];
        end
        if (k < 7) begin
            idx = $urandom_range(0, clamp_len(suf_len) - 1);
            return suf_pat[8*idx +: 8];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one line: noise, usually a prefix, content, often a suffix, tail, line end
    task automatic gen_line();
        int n;
        int roll;
        n = $urandom_range(0, 4);
        repeat (n) push_item(text_byte(), 1'b0);
        if ($urandom_range(0, 9) < 8)
            push_pattern(pref_pat, clamp_len(pref_len));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
        repeat (n) push_item(text_byte(), 1'b0);
        if ($urandom_range(0, 9) < 7)
            push_pattern(suf_pat, clamp_len(suf_len));
        n = $urandom_range(0, 3);
        repeat (n) push_item(text_byte(), 1'b0);
        roll = $urandom_range(0, 9);
        if (roll < 7)
            push_item(dte_pkg::NEWLINE_CODE, 1'b0);
        else if (roll < 9)
            push_item(text_byte(), 1'b1);
        else
            push_item(dte_pkg::NEWLINE_CODE, 1'b1);
    endtask

    // pattern bytes: random, one repeated character, or the 0x00/0xff extremes
    function automatic logic [63:0] make_pattern(input int style);
        logic [63:0] p;
        logic [7:0]  b;
        b = 8'($urandom_range(0, 255));
        for (int i = 0; i < dte_pkg::PAT_BYTES; i++) begin
            case (style)
                1:       p[8*i +: 8] = b;
                2:       p[8*i +: 8] = 8'hff;
                3:       p[8*i +: 8] = 8'h00;
                default: p[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
            // a newline inside a pattern could never match
            if (p[8*i +: 8] == dte_pkg::NEWLINE_CODE)
                p[8*i +: 8] = 8'h0b;
        end
        return p;
    endfunction

    // waits until all text is in and every result out, then lets held work settle
    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || due_results.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
    endtask

    // all four registers in one go; the predictor copy follows at once
    task automatic set_patterns(input logic [63:0] pbytes, input logic [3:0] plen,
                                input logic [63:0] sbytes, input logic [3:0] slen);
        write_reg(dte_pkg::REG_PREFIX_BYTES, pbytes);
        write_reg(dte_pkg::REG_PREFIX_LENGTH, {60'd0, plen});
        write_reg(dte_pkg::REG_SUFFIX_BYTES, sbytes);
        write_reg(dte_pkg::REG_SUFFIX_LENGTH, {60'd0, slen});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pref_pat = pbytes;
        pref_len = plen;
        suf_pat  = sbytes;
        suf_len  = slen;
        setting_cnt++;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int          plen_tab[NUM_PHASES];
        int          slen_tab[NUM_PHASES];
        int          start_cnt;
        logic [63:0] pbytes;
        logic [63:0] sbytes;

        // lengths per phase, extremes and out-of-range codes among them
        plen_tab = '{1, 8, 1, 8, 3, 0, 2, 15, 5};
        slen_tab = '{1, 8, 8, 1, 2, 15, 4, 0, 3};

        reset_extractor_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset patterns: prefix and suffix are both a single 0x00
        push_item(8'h41, 1'b0);
        push_item(8'h00, 1'b0);            // prefix mid-line
        push_item(8'h78, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'h00, 1'b0);            // suffix closes with a marker
        push_item(8'h79, 1'b0);            // ignored rest of line
        push_item(dte_pkg::NEWLINE_CODE, 1'b0);
        push_item(8'h00, 1'b1);            // prefix on the last byte: empty record
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);            // suffix straight after prefix: empty record
        push_item(dte_pkg::NEWLINE_CODE, 1'b0);
        push_item(8'h71, 1'b0);            // line without prefix
        push_item(dte_pkg::NEWLINE_CODE, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h62, 1'b1);            // end of input flushes with record_end
        push_item(dte_pkg::NEWLINE_CODE, 1'b1);     // empty line that also ends input
        wait_idle();

        // long suffix holds bytes back, then a shorter one must release the surplus
        set_patterns(64'h23, 4'd1, 64'h214b_5241_4d44_4e45, 4'd8);
        push_item(8'h23, 1'b0);
        push_pattern(64'h65_6463_6261, 5);
        wait_idle();
        set_patterns(64'h23, 4'd1, 64'h4e45, 4'd2);
        push_item(8'h66, 1'b0);
        push_item(8'h45, 1'b0);
        push_item(8'h4e, 1'b0);            // suffix found across the hold window
        push_item(dte_pkg::NEWLINE_CODE, 1'b0);
        wait_idle();

        // random phases, each under its own pattern setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pbytes = make_pattern(ph % 4);
            case (ph % 3)
                0:       sbytes = pbytes;   // suffix equal to prefix
                1:       sbytes = make_pattern((ph + 1) % 4);
                default: sbytes = make_pattern(0);
            endcase
            set_patterns(pbytes, 4'(plen_tab[ph]), sbytes, 4'(slen_tab[ph]));
            if (ph == 4) begin
                // receiver stops for a long stretch while text keeps coming
                sender_eager = 1'b1;
                hold_req     = 1'b1;
            end
            start_cnt = pushed_cnt;
            while (pushed_cnt - start_cnt < PHASE_ITEMS)
                gen_line();
            wait_idle();
            sender_eager = 1'b0;
        end

        repeat (20) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("run covered %0d text items and %0d results in %0d records",
                 accepted_cnt, result_cnt, record_cnt);
        $display("across %0d pattern settings, %0d mismatches", setting_cnt + 1, err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
